FILE: hw/rtl/bta_pkg.sv
// Package for the boundary-tag heap allocator.
// Holds request kinds, status codes and the shared payload types; no dependencies.
package bta_pkg;
    localparam logic [1:0] KIND_FIRST = 2'd0;
    localparam logic [1:0] KIND_BEST  = 2'd1;
    localparam logic [1:0] KIND_FREE  = 2'd2;
    localparam logic [1:0] KIND_QUERY = 2'd3;

    localparam logic [1:0] ST_DONE    = 2'd0;
    localparam logic [1:0] ST_NOFIT   = 2'd1;
    localparam logic [1:0] ST_ZERO    = 2'd2;
    localparam logic [1:0] ST_ISFREE  = 2'd3;

    localparam int TAG_BYTES = 8;
    localparam int SPLIT_MIN = 16;

    typedef struct packed {
        logic [1:0]  kind;
        logic [15:0] request_bytes;
        logic [31:0] block_address;
    } t_req;

    typedef struct packed {
        logic [1:0]  status;
        logic [31:0] payload_address;
        logic [16:0] block_bytes;
        logic        block_is_free;
    } t_rsp;
endpackage

FILE: hw/rtl/bta_if.sv
// Valid/ready channel interfaces for the heap allocator.
// Depends on bta_pkg for the payload types.
interface bta_req_if;
    logic          valid;
    logic          ready;
    bta_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bta_rsp_if;
    logic          valid;
    logic          ready;
    bta_pkg::t_rsp data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface bta_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] data;
    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

FILE: hw/rtl/boundary_tag_heap_allocator_top.sv
// Top level of the boundary-tag heap allocator: sequencer and header tag memory.
// Depends on bta_pkg and the channel interfaces in bta_if.sv.
//
//  channel   | dir | payload
//  i_cfg     | in  | heap_base word
//  i_req     | in  | kind, request_bytes, block_address
//  o_rsp     | out | status, payload_address, block_bytes, block_is_free
//
// An item walks the header chain one tag read per block; the smallest block is 10
// bytes, so blocks <= HEAP_BYTES/10. The tag memory has a registered read port,
// which sets the pace of the walk. After reset a pass writes one entry a cycle over
// SPAN/2 entries (HEAP_BYTES/2 rounded up), zeroing all but the first header, which
// gets the initial free size, before the first item is taken.
// The result waits in an output register; the next item is taken once it is gone.
module boundary_tag_heap_allocator_top #(
    parameter int HEAP_BYTES  = 4096,
    parameter int MIN_PAYLOAD = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bta_cfg_if.sink     i_cfg,
    bta_req_if.sink     i_req,
    bta_rsp_if.source   o_rsp
);
    import bta_pkg::*;

    localparam int SPAN  = HEAP_BYTES + (HEAP_BYTES % 2);
    localparam int SLOTS = SPAN / 2;
    localparam int AW    = $clog2(SLOTS);
    localparam int OW    = AW + 1;              // byte offset width
    localparam int SW    = OW + 1;              // size/sum width
    localparam logic [SW-1:0] END_TAG  = SW'(SPAN - 4);
    localparam logic [SW-1:0] FIRST_H  = SW'(4);
    localparam logic [SW-1:0] INIT_SZ  = SW'(SPAN - TAG_BYTES);
    localparam logic [17:0]   MINP     = 18'(MIN_PAYLOAD + (MIN_PAYLOAD % 2));

    localparam logic [3:0] S_CLR  = 4'd0;
    localparam logic [3:0] S_IDLE = 4'd1;
    localparam logic [3:0] S_RD   = 4'd2;
    localparam logic [3:0] S_EV   = 4'd3;
    localparam logic [3:0] S_SPL  = 4'd4;
    localparam logic [3:0] S_NRD  = 4'd5;
    localparam logic [3:0] S_NEV  = 4'd6;
    localparam logic [3:0] S_PRD  = 4'd7;
    localparam logic [3:0] S_PEV  = 4'd8;
    localparam logic [3:0] S_OUT  = 4'd9;

    // Header tag memory: entry holds size | used, indexed by offset/2.
    logic [SW-1:0] r_mem [SLOTS];
    logic [SW-1:0] r_rd;
    logic [AW-1:0] w_ra, w_wa;
    logic [SW-1:0] w_wd;
    logic          w_we;

    always_ff @(posedge i_clk) begin
        if (w_we) r_mem[w_wa] <= w_wd;
        r_rd <= r_mem[w_ra];
    end

    logic [3:0]    r_st, n_st;
    logic [AW-1:0] r_clr;
    logic [31:0]   r_base;
    t_req          r_req;
    t_rsp          r_rsp, n_rsp;
    logic          r_ov;
    logic [SW-1:0] r_h, n_h, r_need, n_need, r_pick, n_pick, r_psz, n_psz;
    logic [SW-1:0] r_prev, n_prev, r_tgt, n_tgt, r_s, n_s, r_start, n_start;
    logic          r_found, n_found, r_hp, n_hp;

    wire [SW-1:0] sz   = {r_rd[SW-1:1], 1'b0};
    wire          used = r_rd[0];
    wire          bad  = (sz < SW'(2)) || (sz > END_TAG - r_h);
    wire          is_alloc = (r_req.kind == KIND_FIRST) || (r_req.kind == KIND_BEST);
    wire [31:0]   hdr32 = r_req.block_address - r_base - 32'd4;
    wire          tgt_ok = (hdr32[31:OW] == '0);

    // Request rounding, at most 18 bits.
    logic [17:0] rq, need18;
    always_comb begin
        rq = {2'b0, r_req.request_bytes} + {17'b0, r_req.request_bytes[0]};
        if (r_req.kind == KIND_FIRST && rq < MINP) rq = MINP;
        need18 = rq + 18'(TAG_BYTES);
    end

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = (r_st == S_IDLE) && !r_ov;
    assign o_rsp.valid = r_ov;
    assign o_rsp.data  = r_rsp;

    always_comb begin
        n_st = r_st; n_h = r_h; n_need = r_need; n_pick = r_pick; n_psz = r_psz;
        n_prev = r_prev; n_tgt = r_tgt; n_s = r_s; n_start = r_start;
        n_found = r_found; n_hp = r_hp; n_rsp = r_rsp;
        w_ra = r_h[OW-1:1]; w_we = 1'b0; w_wa = r_clr; w_wd = '0;
        unique case (r_st)
            S_CLR: begin
                w_we = 1'b1;
                w_wd = (r_clr == AW'(2)) ? INIT_SZ : '0;
                if (r_clr == AW'(SLOTS - 1)) n_st = S_IDLE;
            end
            S_IDLE: begin
                n_h = FIRST_H; n_found = 1'b0; n_hp = 1'b0; n_prev = '0;
                if (i_req.valid && !r_ov) n_st = S_RD;
            end
            S_RD: begin
                // Start of an item: set up, reject what cannot be served, and issue the first read.
                n_tgt = hdr32[SW-1:0];
                n_need = need18[SW-1:0];
                n_rsp = '0;
                n_rsp.payload_address = is_alloc ? 32'd0 : r_req.block_address;
                if (is_alloc && rq == '0) begin
                    n_rsp.status = ST_ZERO; n_st = S_OUT;
                end else if (is_alloc && need18 > 18'(SPAN)) begin
                    n_rsp.status = ST_NOFIT; n_st = S_OUT;
                end else if (!is_alloc && !tgt_ok) begin
                    n_rsp.status = ST_NOFIT; n_st = S_OUT;
                end else if (r_h >= END_TAG) begin
                    n_rsp.status = ST_NOFIT; n_st = S_OUT;
                end else begin
                    n_st = S_EV;
                end
            end
            S_EV: begin
                n_st = S_RD;
                if (is_alloc) begin
                    if (!bad && !used && sz >= r_need && (!r_found || sz < r_psz)) begin
                        n_found = 1'b1; n_pick = r_h; n_psz = sz;
                    end
                    if (bad || (r_req.kind == KIND_FIRST && !bad && !used && sz >= r_need)
                        || r_h + sz >= END_TAG) begin
                        n_st = S_SPL;
                    end
                end else if (r_h == r_tgt) begin
                    n_s = sz;
                    if (r_req.kind == KIND_QUERY) begin
                        n_rsp.block_bytes = 17'(sz);
                        n_rsp.block_is_free = !used;
                        n_st = S_OUT;
                    end else if (!used) begin
                        n_rsp.status = ST_ISFREE; n_st = S_OUT;
                    end else begin
                        n_start = r_h; n_st = S_NRD;
                    end
                end else if (bad || r_h + sz >= END_TAG) begin
                    n_rsp.status = ST_NOFIT; n_st = S_OUT;
                end else begin
                    n_prev = r_h; n_hp = 1'b1;
                end
                n_h = r_h + sz;
                if (n_st == S_RD) n_st = S_EV;
                w_ra = n_h[OW-1:1];
            end
            S_SPL: begin
                n_st = S_OUT;
                if (!r_found) begin
                    n_rsp.status = ST_NOFIT;
                end else begin
                    w_we = 1'b1;
                    w_wa = r_pick[OW-1:1];
                    // The full size stays in r_psz so the remainder header can use it.
                    if (r_psz - r_need >= SW'(SPLIT_MIN)) begin
                        w_wd = r_need | SW'(1);
                        n_h = r_pick + r_need; n_st = S_PEV;
                        n_rsp.block_bytes = 17'(r_need);
                    end else begin
                        w_wd = r_psz | SW'(1);
                        n_rsp.block_bytes = 17'(r_psz);
                    end
                    n_rsp.payload_address = r_base + 32'(r_pick) + 32'd4;
                end
            end
            S_PEV: begin
                // Remainder header of a split block.
                w_we = 1'b1; w_wa = r_h[OW-1:1]; w_wd = r_psz - r_need;
                n_st = S_OUT;
            end
            S_NRD: begin
                n_h = r_tgt + r_s;
                w_ra = n_h[OW-1:1];
                n_st = S_NEV;
            end
            S_NEV: begin
                if (r_h < END_TAG && !used) n_s = r_s + sz;
                w_ra = r_prev[OW-1:1];
                n_st = S_PRD;
            end
            S_PRD: begin
                // Hold the previous block's tag on the read port for the write-back.
                w_ra = r_prev[OW-1:1];
                n_st = S_OUT;
            end
            S_OUT: begin
                if (r_req.kind == KIND_FREE && r_rsp.status == ST_DONE && r_start == r_tgt) begin
                    w_we = 1'b1;
                    if (r_hp && !used) begin
                        w_wa = r_prev[OW-1:1]; w_wd = r_s + sz;
                    end else begin
                        w_wa = r_tgt[OW-1:1]; w_wd = r_s;
                    end
                end
                n_st = S_IDLE;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_CLR; r_clr <= '0; r_base <= '0; r_ov <= 1'b0;
        end else begin
            if (r_st == S_CLR) r_clr <= r_clr + AW'(1);
            r_st <= n_st;
            if (i_cfg.valid) r_base <= i_cfg.data;
            if (r_st == S_OUT) r_ov <= 1'b1;
            else if (o_rsp.ready) r_ov <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_req.ready && i_req.valid) r_req <= i_req.data;
        r_h <= n_h; r_need <= n_need; r_pick <= n_pick; r_psz <= n_psz;
        r_prev <= n_prev; r_tgt <= n_tgt; r_s <= n_s; r_start <= n_start;
        r_found <= n_found; r_hp <= n_hp; r_rsp <= n_rsp;
    end

    a_ready_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.ready |-> r_st == S_IDLE) else $error("ready outside idle");
    a_no_take_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ov |-> !i_req.ready) else $error("item taken while result pending");
    a_out_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_OUT |=> r_ov) else $error("result lost");
    a_no_write_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_st == S_IDLE |-> !w_we) else $error("tag write while idle");
endmodule
